>>> src/tip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types and constants of the tagged interval profiler.
// ----------------------------------------------------------------------------
package tip_pkg;

	localparam int ENTRIES     = 32;
	localparam int TRIM_DEPTH  = 2;
	localparam int TAG_BITS    = 16;
	localparam int TAG_IN_BITS = 16;
	localparam int SLOT_BITS   = 5;
	localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_BITS   = $clog2(ENTRIES + 1);
	localparam int POS_BITS    = $clog2(TRIM_DEPTH + 1);
	localparam int TIME_BITS   = 64;
	localparam int CALL_BITS   = 32;
	localparam int FREQ_BITS   = 32;
	localparam int UNITS_BITS  = 24;
	localparam int PROD_BITS   = TIME_BITS + UNITS_BITS;
	localparam int CNT_BITS    = $clog2(PROD_BITS);

	localparam logic [UNITS_BITS-1:0] UNITS_PER_SECOND = 24'd10000000;
	localparam logic [FREQ_BITS-1:0]  FREQ_RESET       = 32'd10000000;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DECIDE,
		S_CONV,
		S_RESP
	} state_t;

	typedef logic [TRIM_DEPTH-1:0][TIME_BITS-1:0] trim_t;

	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [TIME_BITS-1:0] start;
		logic [CALL_BITS-1:0] calls;
		logic [TIME_BITS-1:0] total;
		trim_t                top;
		trim_t                bot;
	} entry_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_BITS-1:0]  slot;
		logic [CALL_BITS-1:0]  calls;
		logic [TIME_BITS-1:0]  elapsed;
		logic [TIME_BITS-1:0]  total;
		trim_t                 top;
		trim_t                 bot;
	} result_t;

endpackage

>>> src/tip_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tip_conv
// Bit-serial tick to 100 ns conversion: shift-add multiply by the unit
// constant, then restoring division by the tick frequency, one bit a cycle.
// ----------------------------------------------------------------------------
module tip_conv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tip_pkg::TIME_BITS-1:0] diff,
	input  logic [tip_pkg::FREQ_BITS-1:0] freq,
	output logic                          done,
	output logic [tip_pkg::TIME_BITS-1:0] quot
);
	import tip_pkg::*;

	logic                  mul_q;
	logic                  div_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [PROD_BITS-1:0]  acc_q;
	logic [PROD_BITS-1:0]  mc_q;
	logic [UNITS_BITS-1:0] kbits_q;
	logic [PROD_BITS-1:0]  num_q;
	logic [FREQ_BITS-1:0]  rem_q;
	logic [FREQ_BITS-1:0]  dvs_q;

	logic [PROD_BITS-1:0]  acc_nxt;
	logic [FREQ_BITS:0]    trial;
	logic                  qbit;
	logic [FREQ_BITS:0]    rem_sub;

	always_comb begin
		acc_nxt = kbits_q[0] ? acc_q + mc_q : acc_q;
		trial   = {rem_q, num_q[PROD_BITS-1]};
		qbit    = trial >= {1'b0, dvs_q};
		rem_sub = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mul_q <= 1'b1;
				cnt_q <= CNT_BITS'(UNITS_BITS - 1);
			end else if (mul_q) begin
				if (cnt_q == '0) begin
					mul_q <= 1'b0;
					div_q <= 1'b1;
					cnt_q <= CNT_BITS'(PROD_BITS - 1);
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (div_q) begin
				if (cnt_q == '0) begin
					div_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mc_q    <= {{UNITS_BITS{1'b0}}, diff};
			kbits_q <= UNITS_PER_SECOND;
			dvs_q   <= (freq == '0) ? FREQ_BITS'(1) : freq;
		end else if (mul_q) begin
			acc_q   <= acc_nxt;
			mc_q    <= {mc_q[PROD_BITS-2:0], 1'b0};
			kbits_q <= {1'b0, kbits_q[UNITS_BITS-1:1]};
			// hand the finished product to the divider
			if (cnt_q == '0) begin
				num_q <= acc_nxt;
				rem_q <= '0;
			end
		end else if (div_q) begin
			rem_q <= qbit ? rem_sub[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];
			num_q <= {num_q[PROD_BITS-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = (|num_q[PROD_BITS-1:TIME_BITS]) ? '1 : num_q[TIME_BITS-1:0];

endmodule

>>> src/tagged_interval_profiler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_interval_profiler
// Per-tag interval statistics with a 32-entry region table.
// ----------------------------------------------------------------------------
// Usage: each event transfer on in_* (mode 0 begin, 1 end) gives exactly one
// result transfer on out_*. tick_frequency is to be written on cfg_* only while
// idle, which the block does not enforce; cfg_ready is always high.
// Sequence: the table is searched one entry at a time, a read state and a
// compare state per entry, through the registered read port of the entry
// memory, until a match or the last of the n entries in use (at most 32).
// A begin then passes the decide and respond states. An end also runs the
// bit-serial converter, a multiply pass then a divide pass, between these.
// The input is ready again in the cycle after the result is loaded.
// One event is worked on at a time; in_ready is high only when idle.
// Reset empties the table (fill count to zero) and sets tick_frequency to
// 10000000; the memory itself is not cleared, entries are written on use.
// A stalled receiver holds the result in the output register; a following
// event is taken and processed, then waits until that register is free.
// ----------------------------------------------------------------------------
module tagged_interval_profiler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tip_pkg::FREQ_BITS-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [tip_pkg::TAG_IN_BITS-1:0] tag_id,
	input  logic [tip_pkg::TIME_BITS-1:0]   timestamp,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [tip_pkg::SLOT_BITS-1:0]   slot,
	output logic [tip_pkg::CALL_BITS-1:0]   calls,
	output logic [tip_pkg::TIME_BITS-1:0]   elapsed,
	output logic [tip_pkg::TIME_BITS-1:0]   accumulated,
	output logic [tip_pkg::TIME_BITS-1:0]   largest,
	output logic [tip_pkg::TIME_BITS-1:0]   second_largest,
	output logic [tip_pkg::TIME_BITS-1:0]   smallest,
	output logic [tip_pkg::TIME_BITS-1:0]   second_smallest
);
	import tip_pkg::*;

	localparam int SEC = (TRIM_DEPTH > 1) ? 1 : 0;

	state_t               state_q, state_d;
	logic [FREQ_BITS-1:0] freq_q;
	logic                 mode_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic [TIME_BITS-1:0] ts_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [USED_BITS-1:0] used_q;
	logic                 found_q;
	entry_t               rec_q;
	result_t              res_q;
	result_t              out_q;
	logic                 out_valid_q;

	entry_t               mem [ENTRIES];

	logic                 match;
	logic                 last;
	logic                 full;
	logic                 mem_we;
	logic                 conv_start;
	logic                 res_load;
	logic                 out_load;
	logic [IDX_BITS-1:0]  wr_addr;
	entry_t               new_rec;
	result_t              res_d;
	logic                 conv_done;
	logic [TIME_BITS-1:0] conv_q;
	logic [TIME_BITS:0]   tot_sum;
	logic                 hit_t, hit_b;
	logic [POS_BITS-1:0]  pos_t, pos_b;

	tip_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.diff   (ts_q - rec_q.start),
		.freq   (freq_q),
		.done   (conv_done),
		.quot   (conv_q)
	);

	assign match = rec_q.tag == tag_q;
	assign last  = ({1'b0, idx_q} + 1'b1) == (IDX_BITS + 1)'(used_q);
	assign full  = used_q == USED_BITS'(ENTRIES);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = (used_q == '0) ? S_DECIDE : S_READ;
			S_READ:   state_d = S_CMP;
			S_CMP:    state_d = (match || last) ? S_DECIDE : S_READ;
			S_DECIDE: state_d = (mode_q && found_q) ? S_CONV : S_RESP;
			S_CONV:   if (conv_done) state_d = S_RESP;
			S_RESP:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		conv_start = 1'b0;
		res_load   = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_DECIDE: begin
				res_load   = 1'b1;
				mem_we     = !mode_q && (found_q || !full);
				conv_start = mode_q && found_q;
			end
			S_CONV:   begin
				res_load = conv_done;
				mem_we   = conv_done;
			end
			S_RESP:   out_load = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	// updated entry and result
	always_comb begin
		new_rec = rec_q;
		wr_addr = found_q ? idx_q : used_q[IDX_BITS-1:0];
		tot_sum = {1'b0, rec_q.total} + {1'b0, conv_q};
		hit_t   = 1'b0;
		hit_b   = 1'b0;
		pos_t   = '0;
		pos_b   = '0;
		res_d   = '0;
		if (!mode_q) begin
			new_rec.start = ts_q;
			if (found_q) begin
				new_rec.calls = (rec_q.calls == '1) ? rec_q.calls : rec_q.calls + 1'b1;
			end else begin
				new_rec.tag   = tag_q;
				new_rec.calls = CALL_BITS'(1);
				new_rec.total = '0;
				new_rec.top   = '0;
				new_rec.bot   = '0;
			end
		end else begin
			new_rec.total = tot_sum[TIME_BITS] ? '1 : tot_sum[TIME_BITS-1:0];
			for (int i = 0; i < TRIM_DEPTH; i++) begin
				if (!hit_t && (rec_q.top[i] == '0 || conv_q > rec_q.top[i])) begin
					hit_t = 1'b1;
					pos_t = POS_BITS'(i);
				end
				if (!hit_b && (rec_q.bot[i] == '0 || conv_q < rec_q.bot[i])) begin
					hit_b = 1'b1;
					pos_b = POS_BITS'(i);
				end
			end
			// insert in order, shift later places down
			for (int j = 0; j < TRIM_DEPTH; j++) begin
				if (hit_t && POS_BITS'(j) == pos_t)
					new_rec.top[j] = conv_q;
				else if (hit_t && POS_BITS'(j) > pos_t)
					new_rec.top[j] = rec_q.top[(j > 0) ? j - 1 : 0];
				if (hit_b && POS_BITS'(j) == pos_b)
					new_rec.bot[j] = conv_q;
				else if (hit_b && POS_BITS'(j) > pos_b)
					new_rec.bot[j] = rec_q.bot[(j > 0) ? j - 1 : 0];
			end
		end
		if (!mode_q && !found_q && full) begin
			res_d.status = STAT_FULL;
		end else if (mode_q && !found_q) begin
			res_d.status = STAT_NOT_FOUND;
		end else begin
			res_d.status  = STAT_OK;
			res_d.slot    = SLOT_BITS'(wr_addr);
			res_d.calls   = new_rec.calls;
			res_d.elapsed = mode_q ? conv_q : '0;
			res_d.total   = new_rec.total;
			res_d.top     = new_rec.top;
			res_d.bot     = new_rec.bot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			freq_q      <= FREQ_RESET;
			idx_q       <= '0;
			used_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) freq_q <= cfg_data;
			if (in_valid && in_ready) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (state_q == S_CMP) begin
				if (match) found_q <= 1'b1;
				else if (!last) idx_q <= idx_q + 1'b1;
			end
			// allocate the next free entry
			if (state_q == S_DECIDE && mem_we && !found_q) used_q <= used_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			tag_q  <= tag_id[TAG_BITS-1:0];
			ts_q   <= timestamp;
		end
		if (res_load) res_q <= res_d;
		if (out_load) out_q <= res_q;
	end

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= new_rec;
		if (state_q == S_READ) rec_q <= mem[idx_q];
	end

	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign slot            = out_q.slot;
	assign calls           = out_q.calls;
	assign elapsed         = out_q.elapsed;
	assign accumulated     = out_q.total;
	assign largest         = out_q.top[0];
	assign second_largest  = (TRIM_DEPTH > 1) ? out_q.top[SEC] : '0;
	assign smallest        = out_q.bot[0];
	assign second_smallest = (TRIM_DEPTH > 1) ? out_q.bot[SEC] : '0;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_BITS'(ENTRIES))
		else $error("fill count beyond table size");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> used_q == $past(used_q) + 1'b1)
		else $error("fill count moved by more than one");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && res_q.status == STAT_FULL) |-> full)
		else $error("table full reported with free entries");

	a_conv_owner: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> state_q == S_CONV)
		else $error("conversion finished outside its state");

endmodule
